// File: hw/rtl/aesrps_pkg.sv
`default_nettype none

package aesrps_pkg;

    localparam int NUM_LANES  = 16;
    localparam int BYTE_W     = 8;
    localparam int SBOX_AW    = 8;
    localparam int SBOX_DEPTH = 1 << SBOX_AW;
    localparam int BLOCK_W    = NUM_LANES * BYTE_W;
    localparam int ROWS       = 4;
    localparam int COLS       = NUM_LANES / ROWS;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ROUND = 1'b1;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef byte_t [NUM_LANES-1:0] state_t;

    typedef struct packed {
        logic inverse;
        logic skip_mix;
        logic key_only;
    } round_ctl_t;

    localparam byte_t GF_POLY = 8'h1b;

    function automatic byte_t xtime(input byte_t a);
        return {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? GF_POLY : byte_t'(0));
    endfunction

    function automatic byte_t gmul_9(input byte_t a);
        return xtime(xtime(xtime(a))) ^ a;
    endfunction

    function automatic byte_t gmul_b(input byte_t a);
        return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
    endfunction

    function automatic byte_t gmul_d(input byte_t a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
    endfunction

    function automatic byte_t gmul_e(input byte_t a);
        return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
    endfunction

    // Byte 0 sits in the most significant byte of the word.
    function automatic state_t unpack_state(input logic [BLOCK_W-1:0] v);
        state_t s;
        for (int j = 0; j < NUM_LANES; j++) begin
            s[j] = v[BLOCK_W-1-BYTE_W*j -: BYTE_W];
        end
        return s;
    endfunction

    function automatic logic [BLOCK_W-1:0] pack_state(input state_t s);
        logic [BLOCK_W-1:0] v;
        for (int j = 0; j < NUM_LANES; j++) begin
            v[BLOCK_W-1-BYTE_W*j -: BYTE_W] = s[j];
        end
        return v;
    endfunction

    function automatic state_t shift_fwd(input state_t t);
        state_t s;
        for (int c = 0; c < COLS; c++) begin
            for (int r = 0; r < ROWS; r++) begin
                s[c*ROWS+r] = t[((c + r) % COLS)*ROWS + r];
            end
        end
        return s;
    endfunction

    function automatic state_t shift_inv(input state_t t);
        state_t s;
        for (int c = 0; c < COLS; c++) begin
            for (int r = 0; r < ROWS; r++) begin
                s[c*ROWS+r] = t[((c + COLS - r) % COLS)*ROWS + r];
            end
        end
        return s;
    endfunction

    function automatic state_t mix_state(input state_t t, input logic inv);
        state_t s;
        byte_t a0, a1, a2, a3;
        for (int c = 0; c < COLS; c++) begin
            for (int k = 0; k < ROWS; k++) begin
                a0 = t[c*ROWS + k];
                a1 = t[c*ROWS + (k + 1) % ROWS];
                a2 = t[c*ROWS + (k + 2) % ROWS];
                a3 = t[c*ROWS + (k + 3) % ROWS];
                if (inv) begin
                    s[c*ROWS+k] = gmul_e(a0) ^ gmul_b(a1) ^ gmul_d(a2) ^ gmul_9(a3);
                end else begin
                    s[c*ROWS+k] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                end
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aes_round_programmable_sbox.sv
// One AES-128 round per item, with a substitution table that software loads.
// Input channel s_*: with s_action low an item writes table entry
// s_table_index with s_table_value and gives no result; with s_action high it
// runs one round on s_block_hi/lo with round key s_key_hi/lo, steered by
// s_inverse, s_skip_mix and s_key_only.
// Result channel m_*: one transfer of m_out_hi/lo for every round item, in
// the order the items arrived.
// A round passes through the lane stage, where the sixteen table lanes each
// hold their own copy of the table and are read once per round, and then the
// output stage, which registers the row shift, column mix and key addition.
// Throughput is one item per cycle while the result channel does not stall; a
// round may follow a load in the very next cycle and sees the new entry.
// Reset marks every table entry as unloaded, so the table reads as identity
// until entries are written, and empties the pipeline.
// When the receiver holds m_ready low, the output and lane stages hold, and
// s_ready falls once both are full.
`default_nettype none

module aes_round_programmable_sbox
    import aesrps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [7:0]  s_table_index,
    input  wire logic [7:0]  s_table_value,
    input  wire logic [63:0] s_block_hi,
    input  wire logic [63:0] s_block_lo,
    input  wire logic [63:0] s_key_hi,
    input  wire logic [63:0] s_key_lo,
    input  wire logic        s_inverse,
    input  wire logic        s_skip_mix,
    input  wire logic        s_key_only,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_hi,
    output logic [63:0]      m_out_lo
);

    logic                  in_xfer;
    logic                  rnd_xfer;
    logic                  ld_xfer;
    logic                  out_adv;
    state_t                in_bytes;
    state_t                sub_bytes;
    state_t                raw_bytes;
    state_t                round_out;
    round_ctl_t            in_ctl;

    logic [SBOX_DEPTH-1:0] tbl_written_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    round_ctl_t            s1_ctl_reg;
    state_t                s1_key_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [BLOCK_W-1:0]    m_data_reg;

    assign out_adv  = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_adv;
    assign in_xfer  = s_valid && s_ready;
    assign rnd_xfer = in_xfer && (s_action == ACT_ROUND);
    assign ld_xfer  = in_xfer && (s_action == ACT_LOAD);
    assign in_bytes = unpack_state({s_block_hi, s_block_lo});
    assign in_ctl   = '{inverse: s_inverse, skip_mix: s_skip_mix, key_only: s_key_only};

    for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
        aesrps_sbox_lane u_lane (
            .aclk       (aclk),
            .wr_en      (ld_xfer),
            .wr_idx     (s_table_index),
            .wr_data    (s_table_value),
            .rd_en      (rnd_xfer),
            .rd_addr    (in_bytes[j]),
            .rd_written (tbl_written_reg[in_bytes[j]]),
            .sub_byte   (sub_bytes[j]),
            .raw_byte   (raw_bytes[j])
        );
    end

    aesrps_merge u_merge (
        .sub_bytes (sub_bytes),
        .raw_bytes (raw_bytes),
        .key_bytes (s1_key_reg),
        .ctl       (s1_ctl_reg),
        .result    (round_out)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_ready) begin
            s1_valid_next = rnd_xfer;
        end
        m_valid_next = m_valid_reg;
        if (out_adv) begin
            m_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tbl_written_reg <= '0;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (ld_xfer) begin
                tbl_written_reg[s_table_index] <= 1'b1;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rnd_xfer) begin
            s1_ctl_reg <= in_ctl;
            s1_key_reg <= unpack_state({s_key_hi, s_key_lo});
        end
        if (out_adv && s1_valid_reg) begin
            m_data_reg <= pack_state(round_out);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_out_hi = m_data_reg[BLOCK_W-1 -: 64];
    assign m_out_lo = m_data_reg[63:0];

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_xfer |=> !s1_valid_reg)
        else $error("A table load entered the round pipeline.");

    a_round_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        rnd_xfer |=> s1_valid_reg)
        else $error("An accepted round did not reach the lane stage.");

    a_lane_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && $stable(sub_bytes)
                                        && $stable(raw_bytes)))
        else $error("The lane stage changed while the output stage was stalled.");

    a_lane_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_adv) |=> m_valid_reg)
        else $error("A finished round was lost between lane and output stages.");

    a_table_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_xfer |=> tbl_written_reg[$past(s_table_index)])
        else $error("A loaded table entry was not marked as written.");

endmodule

`default_nettype wire

// File: hw/rtl/aesrps_sbox_lane.sv
`default_nettype none

module aesrps_sbox_lane
    import aesrps_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [SBOX_AW-1:0] wr_idx,
    input  wire byte_t              wr_data,
    input  wire logic               rd_en,
    input  wire logic [SBOX_AW-1:0] rd_addr,
    input  wire logic               rd_written,
    output byte_t                   sub_byte,
    output byte_t                   raw_byte
);

    byte_t mem [SBOX_DEPTH];
    byte_t q_reg;
    byte_t addr_reg;
    logic  written_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            q_reg       <= mem[rd_addr];
            addr_reg    <= rd_addr;
            written_reg <= rd_written;
        end
    end

    // An entry that has never been loaded reads as its own index.
    assign sub_byte = written_reg ? q_reg : addr_reg;
    assign raw_byte = addr_reg;

endmodule

`default_nettype wire

// File: hw/rtl/aesrps_merge.sv
`default_nettype none

module aesrps_merge
    import aesrps_pkg::*;
(
    input  wire state_t     sub_bytes,
    input  wire state_t     raw_bytes,
    input  wire state_t     key_bytes,
    input  wire round_ctl_t ctl,
    output state_t          result
);

    state_t shifted;
    state_t fwd_mixed;
    state_t fwd_out;
    state_t inv_keyed;
    state_t inv_out;

    always_comb begin
        shifted   = ctl.inverse ? shift_inv(sub_bytes) : shift_fwd(sub_bytes);
        fwd_mixed = ctl.skip_mix ? shifted : mix_state(shifted, 1'b0);
        fwd_out   = fwd_mixed ^ key_bytes;
        inv_keyed = shifted ^ key_bytes;
        inv_out   = ctl.skip_mix ? inv_keyed : mix_state(inv_keyed, 1'b1);
        if (ctl.key_only) begin
            result = raw_bytes ^ key_bytes;
        end else if (ctl.inverse) begin
            result = inv_out;
        end else begin
            result = fwd_out;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/aes_round_checker.sv
`default_nettype none

// Follows both channels, keeps its own copy of the substitution table and
// compares every result transfer with the oldest outstanding round.
module aes_round_checker
    import aesrps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_action,
    input  wire logic [7:0]  s_table_index,
    input  wire logic [7:0]  s_table_value,
    input  wire logic [63:0] s_block_hi,
    input  wire logic [63:0] s_block_lo,
    input  wire logic [63:0] s_key_hi,
    input  wire logic [63:0] s_key_lo,
    input  wire logic        s_inverse,
    input  wire logic        s_skip_mix,
    input  wire logic        s_key_only,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [63:0] m_out_hi,
    input  wire logic [63:0] m_out_lo,
    output int               fail_count,
    output int               pending
);

    typedef logic [7:0] octet_t;
    typedef logic [15:0][7:0] lanes_t;

    logic [7:0]   sbox_image [256];
    logic [127:0] expected_rounds [$];
    logic [127:0] want;
    int           mismatches = 0;

    function automatic octet_t gf_product(input octet_t a, input octet_t b);
        octet_t acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (a[i]) begin
                acc = acc ^ b;
            end
            b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    function automatic lanes_t split_bytes(input logic [63:0] hi, input logic [63:0] lo);
        lanes_t s;
        for (int j = 0; j < 8; j++) begin
            s[j]     = hi[63-8*j -: 8];
            s[j + 8] = lo[63-8*j -: 8];
        end
        return s;
    endfunction

    function automatic lanes_t substitute_bytes(input lanes_t t);
        lanes_t s;
        for (int j = 0; j < 16; j++) begin
            s[j] = sbox_image[t[j]];
        end
        return s;
    endfunction

    // A direction of one moves row r left by r columns; three moves it right.
    function automatic lanes_t rotate_rows(input lanes_t t, input int dir);
        lanes_t s;
        s = t;
        for (int r = 1; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                s[c*4 + r] = t[((c + dir*r) & 3)*4 + r];
            end
        end
        return s;
    endfunction

    function automatic lanes_t mix_lanes(input lanes_t t, input octet_t m0, input octet_t m1,
                                         input octet_t m2, input octet_t m3);
        lanes_t s;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                s[c*4 + k] = gf_product(m0, t[c*4 + k])
                           ^ gf_product(m1, t[c*4 + ((k + 1) & 3)])
                           ^ gf_product(m2, t[c*4 + ((k + 2) & 3)])
                           ^ gf_product(m3, t[c*4 + ((k + 3) & 3)]);
            end
        end
        return s;
    endfunction

    function automatic logic [127:0] transform_block(input logic [63:0] bh, input logic [63:0] bl,
                                                     input logic [63:0] kh, input logic [63:0] kl,
                                                     input logic inv, input logic skip,
                                                     input logic konly);
        lanes_t       st;
        lanes_t       rk;
        logic [127:0] v;
        st = split_bytes(bh, bl);
        rk = split_bytes(kh, kl);
        if (konly) begin
            st = st ^ rk;
        end else if (!inv) begin
            st = rotate_rows(substitute_bytes(st), 1);
            if (!skip) begin
                st = mix_lanes(st, 8'h02, 8'h03, 8'h01, 8'h01);
            end
            st = st ^ rk;
        end else begin
            st = substitute_bytes(rotate_rows(st, 3)) ^ rk;
            if (!skip) begin
                st = mix_lanes(st, 8'h0e, 8'h0b, 8'h0d, 8'h09);
            end
        end
        for (int j = 0; j < 16; j++) begin
            v[127-8*j -: 8] = st[j];
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 256; i++) begin
                sbox_image[i] = 8'(i);
            end
            expected_rounds.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rounds.size() == 0) begin
                    $error("Result transfer with no round outstanding: out_hi %h, out_lo %h",
                           m_out_hi, m_out_lo);
                    mismatches++;
                end else begin
                    want = expected_rounds.pop_front();
                    if (m_out_hi !== want[127:64]) begin
                        $error("out_hi: expected %h, got %h", want[127:64], m_out_hi);
                        mismatches++;
                    end
                    if (m_out_lo !== want[63:0]) begin
                        $error("out_lo: expected %h, got %h", want[63:0], m_out_lo);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_action == ACT_ROUND) begin
                    expected_rounds.push_back(transform_block(s_block_hi, s_block_lo,
                                                              s_key_hi, s_key_lo, s_inverse,
                                                              s_skip_mix, s_key_only));
                end else begin
                    sbox_image[s_table_index] = s_table_value;
                end
            end
        end
        pending    <= expected_rounds.size();
        fail_count <= mismatches;
    end

endmodule

`default_nettype wire

// File: tb/sv/aes_round_programmable_sbox_test.sv
`default_nettype none

module aes_round_programmable_sbox_test;
    import aesrps_pkg::*;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_action      = ACT_LOAD;
    logic [7:0]  s_table_index = 8'h00;
    logic [7:0]  s_table_value = 8'h00;
    logic [63:0] s_block_hi    = 64'h0;
    logic [63:0] s_block_lo    = 64'h0;
    logic [63:0] s_key_hi      = 64'h0;
    logic [63:0] s_key_lo      = 64'h0;
    logic        s_inverse     = 1'b0;
    logic        s_skip_mix    = 1'b0;
    logic        s_key_only    = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [63:0] m_out_hi;
    logic [63:0] m_out_lo;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_token     = 0;
    int hold_seen      = 0;
    int hold_count     = 0;
    int fail_count;
    int pending;

    always #4 aclk = ~aclk;

    aes_round_programmable_sbox i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .s_block_hi    (s_block_hi),
        .s_block_lo    (s_block_lo),
        .s_key_hi      (s_key_hi),
        .s_key_lo      (s_key_lo),
        .s_inverse     (s_inverse),
        .s_skip_mix    (s_skip_mix),
        .s_key_only    (s_key_only),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_hi      (m_out_hi),
        .m_out_lo      (m_out_lo)
    );

    aes_round_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .s_block_hi    (s_block_hi),
        .s_block_lo    (s_block_lo),
        .s_key_hi      (s_key_hi),
        .s_key_lo      (s_key_lo),
        .s_inverse     (s_inverse),
        .s_skip_mix    (s_skip_mix),
        .s_key_only    (s_key_only),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_hi      (m_out_hi),
        .m_out_lo      (m_out_lo),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // A new hold token makes the receiver refuse every transfer for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen  <= hold_token;
            hold_count <= 300;
            m_ready    <= 1'b0;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(input logic act, input logic [7:0] idx, input logic [7:0] val,
                             input logic [63:0] bh, input logic [63:0] bl,
                             input logic [63:0] kh, input logic [63:0] kl,
                             input logic inv, input logic skip, input logic konly);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_table_index <= idx;
        s_table_value <= val;
        s_block_hi    <= bh;
        s_block_lo    <= bl;
        s_key_hi      <= kh;
        s_key_lo      <= kl;
        s_inverse     <= inv;
        s_skip_mix    <= skip;
        s_key_only    <= konly;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [7:0] val);
        send_item(ACT_LOAD, idx, val, pick_word(), pick_word(), pick_word(), pick_word(),
                  1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_round(input logic [63:0] bh, input logic [63:0] bl,
                              input logic [63:0] kh, input logic [63:0] kl,
                              input logic inv, input logic skip, input logic konly);
        send_item(ACT_ROUND, 8'($urandom), 8'($urandom), bh, bl, kh, kl, inv, skip, konly);
    endtask

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) begin
                send_load(8'($urandom), 8'($urandom));
            end else begin
                send_round(pick_word(), pick_word(), pick_word(), pick_word(),
                           1'($urandom), 1'($urandom), $urandom_range(3) == 0);
            end
        end
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_round('1, '1, 64'h0, 64'h0, 1'b1, 1'b1, 1'b1);
        send_round(64'h0, 64'h0, '1, '1, 1'b0, 1'b0, 1'b0);
        send_round('1, '1, '1, '1, 1'b0, 1'b1, 1'b0);
        send_round(64'h0011223344556677, 64'h8899aabbccddeeff, 64'h0, 64'h0, 1'b1, 1'b0, 1'b0);
        send_round(64'h0011223344556677, 64'h8899aabbccddeeff, '1, 64'h0, 1'b1, 1'b1, 1'b0);
        send_round(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h0f0f0f0f0f0f0f0f,
                   64'hf0f0f0f0f0f0f0f0, 1'b0, 1'b0, 1'b1);
        send_load(8'h00, 8'hff);
        send_round(64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0, 1'b0);
        send_load(8'hff, 8'h00);
        send_round('1, '1, 64'h0, 64'h0, 1'b1, 1'b0, 1'b0);
        send_load(8'h80, 8'h55);
        send_round(64'h8080808080808080, 64'h8080808080808080, 64'h0, 64'h0, 1'b0, 1'b1, 1'b0);
        send_load(8'h7f, 8'haa);
        send_round(64'h7f7f7f7f80808080, 64'h00000000ffffffff, 64'h0, '1, 1'b1, 1'b1, 1'b0);
        send_round(64'h7f7f7f7f80808080, 64'h00000000ffffffff, '1, 64'h0, 1'b0, 1'b0, 1'b0);
        wait_for_results();

        random_items(170);

        // The receiver holds off while the sender keeps offering, so the block fills up.
        hold_token <= hold_token + 1;
        random_items(30);
        wait_for_results();

        send_idle_pct = 60;
        random_items(170);
        wait_for_results();

        send_idle_pct = 0;
        recv_stall_pct <= 60;
        random_items(170);
        wait_for_results();

        send_idle_pct = 24;
        recv_stall_pct <= 24;
        random_items(170);

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3200000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
